[rtl/bdne_pkg.sv]
// Shared types and constants for the beam debounce / note event unit.
// No dependencies.
`default_nettype none

package bdne_pkg;

  localparam int NUM_BEAMS = 7;
  localparam int IDX_W     = 3;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DW    = 8;

  localparam logic [CFG_IDX_W-1:0] REG_BASE_NOTE     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NOTE_INTERVAL = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_VELOCITY      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MIDI_ENABLE   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_AUDIO_ENABLE  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_MS   = 3'd5;

  typedef struct packed {
    logic [6:0]  beam_bits;
    logic [31:0] now_ms;
  } in_beat_t;

  typedef struct packed {
    logic [2:0] beam_index;
    logic       is_note_on;
    logic [7:0] note;
    logic [6:0] note_velocity;
    logic       to_midi;
    logic       to_audio;
    logic       led_on;
    logic       last_event;
  } out_beat_t;

  typedef struct packed {
    logic [6:0] base_note;
    logic [6:0] note_interval;
    logic [6:0] velocity;
    logic       midi_enable;
    logic       audio_enable;
    logic [7:0] debounce_ms;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    base_note:     7'd60,
    note_interval: 7'd2,
    velocity:      7'd100,
    midi_enable:   1'b1,
    audio_enable:  1'b1,
    debounce_ms:   8'd20
  };

  // one queued poll: which beams changed, their new level, LED after each event
  typedef struct packed {
    logic [NUM_BEAMS-1:0] mask;
    logic [NUM_BEAMS-1:0] level;
    logic [NUM_BEAMS-1:0] led;
  } poll_entry_t;

endpackage

`default_nettype wire

[rtl/bdne_front.sv]
// Front end: accepts polls, runs the debounce check and owns beam state.
// Depends on bdne_pkg.
`default_nettype none

module bdne_front (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   in_valid,
  output logic                  in_ready,
  input  bdne_pkg::in_beat_t    in_data,
  input  wire [7:0]             debounce_ms,
  output logic                  push_valid,
  output bdne_pkg::poll_entry_t push_data,
  input  wire                   push_ready
);
  import bdne_pkg::*;

  logic [NUM_BEAMS-1:0] stable;
  logic [31:0]          change_time [NUM_BEAMS];
  logic                 led;

  logic [31:0]          elapsed [NUM_BEAMS];
  logic [NUM_BEAMS-1:0] mask;
  logic [NUM_BEAMS-1:0] stable_next;
  logic [NUM_BEAMS-1:0] led_vec;
  logic                 led_next;
  logic                 accept;

  always_comb begin
    for (int i = 0; i < NUM_BEAMS; i++) begin
      elapsed[i] = in_data.now_ms - change_time[i];
      mask[i] = (in_data.beam_bits[i] != stable[i]) &&
                (elapsed[i] > {24'd0, debounce_ms});
    end
  end

  assign stable_next = stable ^ mask;

  // LED follows beam order; a release sees levels updated up to its own beam
  always_comb begin
    logic [NUM_BEAMS-1:0] view;
    logic                 l;
    view = stable;
    l    = led;
    for (int i = 0; i < NUM_BEAMS; i++) begin
      for (int j = 0; j < NUM_BEAMS; j++) begin
        view[j] = (j <= i) ? stable_next[j] : stable[j];
      end
      if (mask[i]) begin
        if (stable_next[i]) begin
          l = 1'b1;
        end else if (!(|view)) begin
          l = 1'b0;
        end
      end
      led_vec[i] = l;
    end
    led_next = l;
  end

  assign in_ready   = push_ready;
  assign accept     = in_valid && in_ready;
  assign push_valid = accept && (|mask);
  assign push_data  = '{mask: mask, level: stable_next, led: led_vec};

  always_ff @(posedge clk) begin
    if (rst) begin
      stable <= '0;
      led    <= 1'b0;
      for (int i = 0; i < NUM_BEAMS; i++) begin
        change_time[i] <= '0;
      end
    end else if (accept) begin
      stable <= stable_next;
      led    <= led_next;
      for (int i = 0; i < NUM_BEAMS; i++) begin
        if (mask[i]) begin
          change_time[i] <= in_data.now_ms;
        end
      end
    end
  end

endmodule

`default_nettype wire

[rtl/bdne_queue.sv]
// Small FIFO of classified polls between front and back end.
// Depends on bdne_pkg.
`default_nettype none

module bdne_queue #(
  parameter int DEPTH = 2
) (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   push_valid,
  output logic                  push_ready,
  input  bdne_pkg::poll_entry_t push_data,
  output logic                  pop_valid,
  input  wire                   pop_ready,
  output bdne_pkg::poll_entry_t pop_data
);
  import bdne_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  poll_entry_t   slots [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign push_ready = (count != CW'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

`default_nettype wire

[rtl/bdne_back.sv]
// Back end: walks the changed beams of a poll and emits one event per beat.
// Depends on bdne_pkg.
`default_nettype none

module bdne_back (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   pop_valid,
  output logic                  pop_ready,
  input  bdne_pkg::poll_entry_t pop_data,
  input  bdne_pkg::cfg_t        cfg,
  output logic                  out_valid,
  input  wire                   out_ready,
  output bdne_pkg::out_beat_t   out_data
);
  import bdne_pkg::*;

  logic                 cur_valid;
  logic [NUM_BEAMS-1:0] rem;
  logic [NUM_BEAMS-1:0] level;
  logic [NUM_BEAMS-1:0] led;

  logic                 advance;
  logic                 emit;
  logic [IDX_W-1:0]     sel_idx;
  logic [NUM_BEAMS-1:0] rem_after;
  logic                 last;
  logic [9:0]           prod;
  logic [7:0]           note;

  always_comb begin
    sel_idx = '0;
    for (int i = NUM_BEAMS - 1; i >= 0; i--) begin
      if (rem[i]) begin
        sel_idx = IDX_W'(i);
      end
    end
  end

  always_comb begin
    rem_after = rem;
    rem_after[sel_idx] = 1'b0;
  end

  assign last      = (rem_after == '0);
  assign advance   = !out_valid || out_ready;
  assign emit      = advance && cur_valid;
  assign pop_ready = !cur_valid || (emit && last);
  assign prod      = 10'(sel_idx) * 10'(cfg.note_interval);
  assign note      = {1'b0, cfg.base_note} + prod[7:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (advance) begin
        out_valid <= cur_valid;
      end
      if (pop_valid && pop_ready) begin
        cur_valid <= 1'b1;
      end else if (emit && last) begin
        cur_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop_valid && pop_ready) begin
      rem   <= pop_data.mask;
      level <= pop_data.level;
      led   <= pop_data.led;
    end else if (emit) begin
      rem <= rem_after;
    end
    if (emit) begin
      out_data.beam_index    <= sel_idx;
      out_data.is_note_on    <= level[sel_idx];
      out_data.note          <= note;
      out_data.note_velocity <= level[sel_idx] ? cfg.velocity : '0;
      out_data.to_midi       <= cfg.midi_enable;
      out_data.to_audio      <= cfg.audio_enable;
      out_data.led_on        <= led[sel_idx];
      out_data.last_event    <= last;
    end
  end

`ifndef SYNTHESIS
  a_on_lights_led: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.is_note_on |-> out_data.led_on)
    else $error("note-on without LED");

  a_off_zero_vel: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.is_note_on |-> out_data.note_velocity == '0)
    else $error("note-off with velocity");

  a_busy_has_work: assert property (@(posedge clk) disable iff (rst)
    cur_valid |-> rem != '0)
    else $error("active poll with no beams left");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid && !cur_valid)
    else $error("output busy after reset");
`endif

endmodule

`default_nettype wire

[rtl/beam_debounce_note_events_unit.sv]
// Top level of the beam debounce / note event unit: config registers,
// front end, poll queue and event back end. Depends on bdne_pkg and submodules.
//
//   channel  dir  payload       beat
//   in       in   in_beat_t     one poll (beam bits, ms timestamp)
//   out      out  out_beat_t    one note event
//   cfg      in   index, data   one register write
//
// A poll is taken each cycle while the queue has room; state updates on accept.
// The back end sends one event per cycle unless out_ready stalls it, so a poll
// with k changes gives k events; at most 7 events per poll.
// Output register lets the back end stall alone; queue depth is QUEUE_DEPTH polls.
// Reset restores register defaults and clears beam state; no clearing pass.
`default_nettype none

module beam_debounce_note_events_unit #(
  parameter int QUEUE_DEPTH = 2
) (
  input  wire                           clk,
  input  wire                           rst,
  input  wire                           in_valid,
  output logic                          in_ready,
  input  bdne_pkg::in_beat_t            in_data,
  output logic                          out_valid,
  input  wire                           out_ready,
  output bdne_pkg::out_beat_t           out_data,
  input  wire                           cfg_valid,
  output logic                          cfg_ready,
  input  wire [bdne_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire [bdne_pkg::CFG_DW-1:0]    cfg_data
);
  import bdne_pkg::*;

  cfg_t        cfg;
  logic        push_valid;
  logic        push_ready;
  poll_entry_t push_data;
  logic        pop_valid;
  logic        pop_ready;
  poll_entry_t pop_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_BASE_NOTE:     cfg.base_note     <= cfg_data[6:0];
        REG_NOTE_INTERVAL: cfg.note_interval <= cfg_data[6:0];
        REG_VELOCITY:      cfg.velocity      <= cfg_data[6:0];
        REG_MIDI_ENABLE:   cfg.midi_enable   <= cfg_data[0];
        REG_AUDIO_ENABLE:  cfg.audio_enable  <= cfg_data[0];
        REG_DEBOUNCE_MS:   cfg.debounce_ms   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  bdne_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .debounce_ms (cfg.debounce_ms),
    .push_valid  (push_valid),
    .push_data   (push_data),
    .push_ready  (push_ready)
  );

  bdne_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  bdne_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .cfg       (cfg),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

[verif/tb_beam_debounce_note_events_unit.sv]
// Testbench for beam_debounce_note_events_unit: directed and random polls, a scoreboard
// class that predicts note events per accepted poll and checks every output beat.
// Depends on bdne_pkg and the unit's RTL.
import bdne_pkg::*;

class note_event_board;
  cfg_t                 regs;
  logic [NUM_BEAMS-1:0] stable;
  logic [31:0]          changed_at [NUM_BEAMS];
  logic                 led;
  out_beat_t            pending_events[$];
  int                   errors;
  int                   polls;
  int                   checked;

  function new();
    regs    = CFG_RESET;
    stable  = '0;
    led     = 1'b0;
    errors  = 0;
    polls   = 0;
    checked = 0;
    for (int i = 0; i < NUM_BEAMS; i++) changed_at[i] = '0;
  endfunction

  function int pending();
    return pending_events.size();
  endfunction

  function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DW-1:0] d);
    case (idx)
      REG_BASE_NOTE:     regs.base_note     = d[6:0];
      REG_NOTE_INTERVAL: regs.note_interval = d[6:0];
      REG_VELOCITY:      regs.velocity      = d[6:0];
      REG_MIDI_ENABLE:   regs.midi_enable   = d[0];
      REG_AUDIO_ENABLE:  regs.audio_enable  = d[0];
      REG_DEBOUNCE_MS:   regs.debounce_ms   = d;
      default: ;
    endcase
  endfunction

  // accepted poll: run the debounce per beam and queue the events it causes
  function void log_poll(in_beat_t b);
    out_beat_t   ev;
    out_beat_t   held;
    bit          have_held;
    logic        raw;
    logic [31:0] age;
    logic [31:0] note_sum;
    have_held = 0;
    held = '0;
    polls++;
    for (int i = 0; i < NUM_BEAMS; i++) begin
      raw = b.beam_bits[i];
      if (raw == stable[i]) continue;
      age = b.now_ms - changed_at[i];
      if (age <= 32'(regs.debounce_ms)) continue;
      stable[i] = raw;
      changed_at[i] = b.now_ms;
      if (raw) led = 1'b1;
      else if (stable == '0) led = 1'b0;
      note_sum = 32'(regs.base_note) + 32'(i) * 32'(regs.note_interval);
      ev.beam_index    = 3'(i);
      ev.is_note_on    = raw;
      ev.note          = note_sum[7:0];
      ev.note_velocity = raw ? regs.velocity : 7'd0;
      ev.to_midi       = regs.midi_enable;
      ev.to_audio      = regs.audio_enable;
      ev.led_on        = led;
      ev.last_event    = 1'b0;
      if (have_held) pending_events.push_back(held);
      held = ev;
      have_held = 1;
    end
    if (have_held) begin
      held.last_event = 1'b1;
      pending_events.push_back(held);
    end
  endfunction

  function void cmp_field(string field, logic [31:0] want, logic [31:0] got, time stamp,
                          inout bit bad);
    if (want !== got) begin
      if (errors < 40)
        $display("%0t: %s mismatch, expected %0d, actual %0d", stamp, field, want, got);
      bad = 1;
    end
  endfunction

  function void check_event(out_beat_t got, time stamp);
    out_beat_t want;
    bit        bad;
    bad = 0;
    if (pending_events.size() == 0) begin
      if (errors < 40)
        $display("%0t: unexpected beat, expected none, actual %h", stamp, got);
      errors++;
      return;
    end
    want = pending_events.pop_front();
    checked++;
    cmp_field("beam_index", 32'(want.beam_index), 32'(got.beam_index), stamp, bad);
    cmp_field("is_note_on", 32'(want.is_note_on), 32'(got.is_note_on), stamp, bad);
    cmp_field("note", 32'(want.note), 32'(got.note), stamp, bad);
    cmp_field("note_velocity", 32'(want.note_velocity), 32'(got.note_velocity), stamp, bad);
    cmp_field("to_midi", 32'(want.to_midi), 32'(got.to_midi), stamp, bad);
    cmp_field("to_audio", 32'(want.to_audio), 32'(got.to_audio), stamp, bad);
    cmp_field("led_on", 32'(want.led_on), 32'(got.led_on), stamp, bad);
    cmp_field("last_event", 32'(want.last_event), 32'(got.last_event), stamp, bad);
    if (bad) errors++;
  endfunction
endclass

module tb_beam_debounce_note_events_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_B = 3'd7;
  localparam int SETTLE_CYCLES = 12;
  localparam int LONG_STALL    = 300;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  in_beat_t             in_data = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  out_beat_t            out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DW-1:0]    cfg_data = '0;

  note_event_board sb;
  int              send_idle_pct = 0;
  int              recv_idle_pct = 0;
  bit              stall_request = 0;
  int              stall_left = 0;
  int              reg_writes = 0;
  logic [6:0]      cur_bits = '0;
  logic [31:0]     cur_now = '0;

  beam_debounce_note_events_unit u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  always @(negedge clk) begin
    if (stall_request) begin
      stall_left = LONG_STALL;
      stall_request = 0;
    end
    if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) sb.check_event(out_data, $time);
      if (in_valid && in_ready) sb.log_poll(in_data);
      if (cfg_valid && cfg_ready) begin
        sb.write_reg(cfg_index, cfg_data);
        reg_writes++;
      end
    end
  end

  task automatic send_poll(input logic [6:0] bits, input logic [31:0] stamp_ms);
    in_beat_t b;
    b.beam_bits = bits;
    b.now_ms = stamp_ms;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DW-1:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // stop offering polls and wait until every predicted event has been seen
  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (sb.pending() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic apply_setting(input logic [6:0] base, input logic [6:0] step,
                               input logic [6:0] vel, input logic midi, input logic audio,
                               input logic [7:0] deb);
    write_reg(REG_BASE_NOTE, {1'b0, base});
    write_reg(REG_NOTE_INTERVAL, {1'b0, step});
    write_reg(REG_VELOCITY, {1'b0, vel});
    write_reg(REG_MIDI_ENABLE, {7'd0, midi});
    write_reg(REG_AUDIO_ENABLE, {7'd0, audio});
    write_reg(REG_DEBOUNCE_MS, deb);
  endtask

  task automatic random_polls(input int count);
    int         pick;
    logic [6:0] flips;
    for (int k = 0; k < count; k++) begin
      pick = $urandom_range(99);
      if (pick < 5) cur_now = $urandom;
      else if (pick < 9) cur_now = cur_now - $urandom_range(1, 60);
      else cur_now = cur_now + $urandom_range(0, 2 * sb.regs.debounce_ms + 2);
      if ($urandom_range(9) == 0) begin
        cur_bits = 7'($urandom_range(127));
      end else begin
        flips = '0;
        for (int j = 0; j < NUM_BEAMS; j++) if ($urandom_range(3) == 0) flips[j] = 1'b1;
        cur_bits = cur_bits ^ flips;
      end
      send_poll(cur_bits, cur_now);
    end
  endtask

  initial begin
    #(5_000_000);
    $display("tb_beam_debounce_note_events_unit: FAIL");
    $finish;
  end

  initial begin
    sb = new();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset settings: lockout edge, all on / all off, backward and wrapping time
    send_poll(7'h7f, 32'd0);
    send_poll(7'h7f, 32'd21);
    send_poll(7'h00, 32'd41);
    send_poll(7'h00, 32'd42);
    send_poll(7'h01, 32'd10);
    send_poll(7'h40, 32'hffff_ffff);
    send_poll(7'h00, 32'h0000_0014);
    drain();

    // outputs disabled, oversized data, unmapped indexes, zero lockout
    write_reg(REG_MIDI_ENABLE, 8'd0);
    write_reg(REG_AUDIO_ENABLE, 8'd0);
    write_reg(REG_BASE_NOTE, 8'hff);
    write_reg(REG_NOTE_INTERVAL, 8'd127);
    write_reg(REG_VELOCITY, 8'hff);
    write_reg(REG_UNMAPPED_A, 8'hff);
    write_reg(REG_UNMAPPED_B, 8'h00);
    write_reg(REG_DEBOUNCE_MS, 8'd0);
    send_poll(7'h55, 32'h0000_0100);
    send_poll(7'h2a, 32'h0000_0100);
    send_poll(7'h2a, 32'h0000_0101);
    send_poll(7'h7f, 32'h8000_0000);
    send_poll(7'h00, 32'h8000_0001);
    drain();

    write_reg(REG_DEBOUNCE_MS, 8'd255);
    write_reg(REG_MIDI_ENABLE, 8'd1);
    write_reg(REG_AUDIO_ENABLE, 8'd1);
    send_poll(7'h7f, 32'h8000_0100);
    send_poll(7'h7f, 32'h8000_0101);
    send_poll(7'h00, 32'h8000_0200);
    send_poll(7'h00, 32'h8000_0201);
    drain();
    cur_now = 32'h8000_0201;
    cur_bits = '0;

    apply_setting(7'd127, 7'd127, 7'd127, 1'b0, 1'b1, 8'd0);
    send_idle_pct = 29;
    recv_idle_pct = 57;
    random_polls(145);
    drain();

    apply_setting(7'd0, 7'd0, 7'd0, 1'b1, 1'b0, 8'd255);
    send_idle_pct = 57;
    recv_idle_pct = 29;
    random_polls(145);
    drain();

    apply_setting(7'($urandom_range(127)), 7'($urandom_range(127)),
                  7'($urandom_range(127)), 1'b1, 1'b1, 8'($urandom_range(1, 40)));
    send_idle_pct = 0;
    recv_idle_pct = 0;
    @(posedge clk);
    stall_request = 1;
    @(negedge clk);
    random_polls(145);
    drain();

    $display("covered %0d polls, %0d note events checked, %0d register writes",
             sb.polls, sb.checked, reg_writes);
    $display("lockout 0 to 255, wrapping and backward timestamps, disabled outputs, stalls");
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb_beam_debounce_note_events_unit: PASS");
    end else begin
      $display("tb_beam_debounce_note_events_unit: FAIL");
    end
    $finish;
  end
endmodule
